// File: sv/icc_pkg.sv
package icc_pkg;

  // Number of byte lanes carried by one word.
  localparam int unsigned ByteLanes = 4;
  // Width of the byte count field.
  localparam int unsigned CountW = 3;
  // Width of the one's-complement sum.
  localparam int unsigned SumW = 16;
  // Width of one data byte.
  localparam int unsigned ByteW = 8;

  // Per-lane control: lane enabled and lane placed in the high half of a word.
  typedef struct packed {
    logic en;
    logic hi;
  } lane_ctrl_t;

  // One result word as it travels through the output buffer.
  typedef struct packed {
    logic [ByteLanes-1:0][ByteW-1:0] copy;
    logic [CountW-1:0]               count;
    logic [SumW-1:0]                 total;
    logic [SumW-1:0]                 final_sum;
    logic                            cks_valid;
  } result_t;

endpackage

// File: sv/icc_lane.sv
module icc_lane (
  input  logic [7:0]          byte_i,
  input  icc_pkg::lane_ctrl_t ctrl_i,
  output logic [7:0]          copy_o,
  output logic [15:0]         term_o
);
  import icc_pkg::*;

  // Mask lanes beyond the count; place the byte in the high or low half of a word.
  always_comb begin
    copy_o = ctrl_i.en ? byte_i : '0;
    term_o = ctrl_i.hi ? {copy_o, 8'h00} : {8'h00, copy_o};
  end

endmodule

// File: sv/icc_merge.sv
module icc_merge (
  input  logic [icc_pkg::SumW-1:0]                          base_i,
  input  logic [icc_pkg::ByteLanes-1:0][icc_pkg::SumW-1:0] term_i,
  output logic [icc_pkg::SumW-1:0]                          sum_o
);
  import icc_pkg::*;

  localparam int unsigned WideW = SumW + $clog2(ByteLanes + 1);
  localparam int unsigned CarryW = WideW - SumW;

  logic [WideW-1:0] wide_sum;
  logic [SumW:0]    fold1;
  logic [SumW-1:0]  fold2;

  // Add the lane terms to the running sum.
  always_comb begin
    wide_sum = WideW'(base_i);
    for (int unsigned k = 0; k < ByteLanes; k++) begin
      wide_sum = wide_sum + WideW'(term_i[k]);
    end
  end

  // Two end-around carry folds bring the sum back to 16 bits.
  always_comb begin
    fold1 = (SumW+1)'(wide_sum[SumW-1:0]) + (SumW+1)'(wide_sum[WideW-1 -: CarryW]);
    fold2 = fold1[SumW-1:0] + SumW'(fold1[SumW]);
  end

  assign sum_o = fold2;

endmodule

// File: sv/icc_skid.sv
module icc_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  icc_pkg::result_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output icc_pkg::result_t out_data_o
);
  import icc_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, out_data_d;
  result_t skid_data_q, skid_data_d;
  logic    accept;
  logic    take;

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i & ~skid_valid_q;
  assign take        = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The output register refills from the skid stage first, then from the input.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = accept;
        out_data_d  = in_data_i;
      end
    end else if (accept) begin
      skid_valid_d = 1'b1;
      skid_data_d  = in_data_i;
    end
  end

  // Valid flags reset; payload registers do not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

endmodule

// File: sv/internet_checksum_copy_stream.sv
// Internet checksum copy stream: four byte lanes summed into a 16-bit one's-complement total.
// Each accepted word's result is registered in the output buffer's output or skid register.
// Throughput: one word per cycle while in_stall_o is low; the running sum loop holds one register.
// A two-entry output buffer keeps input accepting while a result waits to be taken.
// Reset (rst_ni low, asynchronous) clears the sum, the parity and both output valid flags.
module internet_checksum_copy_stream (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_0_i,
  input  logic [7:0]  byte_1_i,
  input  logic [7:0]  byte_2_i,
  input  logic [7:0]  byte_3_i,
  input  logic [2:0]  byte_count_i,
  input  logic        chain_start_i,
  input  logic        chain_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  copy_0_o,
  output logic [7:0]  copy_1_o,
  output logic [7:0]  copy_2_o,
  output logic [7:0]  copy_3_o,
  output logic [2:0]  copy_count_o,
  output logic [15:0] running_total_o,
  output logic [15:0] final_checksum_o,
  output logic        checksum_valid_o
);
  import icc_pkg::*;

  logic [SumW-1:0]                 acc_sum_q, acc_sum_d;
  logic                            odd_q, odd_d;
  logic [ByteLanes-1:0][ByteW-1:0] bytes;
  logic [ByteLanes-1:0][ByteW-1:0] copies;
  logic [ByteLanes-1:0][SumW-1:0]  terms;
  lane_ctrl_t [ByteLanes-1:0]      lane_ctrl;
  logic [CountW-1:0]               count;
  logic [SumW-1:0]                 base_sum;
  logic                            base_odd;
  logic [SumW-1:0]                 new_sum;
  logic                            accept;
  result_t                         res;
  result_t                         out_res;

  assign bytes = {byte_3_i, byte_2_i, byte_1_i, byte_0_i};
  assign accept = in_valid_i & ~in_stall_o;

  // Saturate the count and apply the start flag to the stored state.
  always_comb begin
    count    = (byte_count_i > CountW'(ByteLanes)) ? CountW'(ByteLanes) : byte_count_i;
    base_sum = chain_start_i ? '0 : acc_sum_q;
    base_odd = chain_start_i ? 1'b0 : odd_q;
  end

  // Each lane is enabled below the count; parity plus lane index picks its half.
  always_comb begin
    for (int unsigned k = 0; k < ByteLanes; k++) begin
      lane_ctrl[k].en = (CountW'(k) < count);
      lane_ctrl[k].hi = ~(base_odd ^ k[0]);
    end
  end

  for (genvar g = 0; g < ByteLanes; g++) begin : g_lane
    icc_lane u_lane (
      .byte_i (bytes[g]),
      .ctrl_i (lane_ctrl[g]),
      .copy_o (copies[g]),
      .term_o (terms[g])
    );
  end

  icc_merge u_merge (
    .base_i (base_sum),
    .term_i (terms),
    .sum_o  (new_sum)
  );

  // Update the running sum and parity on every accepted word.
  always_comb begin
    acc_sum_d = acc_sum_q;
    odd_d     = odd_q;
    if (accept) begin
      acc_sum_d = new_sum;
      odd_d     = base_odd ^ count[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_sum_q <= '0;
      odd_q     <= 1'b0;
    end else begin
      acc_sum_q <= acc_sum_d;
      odd_q     <= odd_d;
    end
  end

  // Assemble the result word.
  always_comb begin
    res.copy      = copies;
    res.count     = count;
    res.total     = new_sum;
    res.final_sum = chain_end_i ? ~new_sum : '0;
    res.cks_valid = chain_end_i;
  end

  icc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign copy_0_o         = out_res.copy[0];
  assign copy_1_o         = out_res.copy[1];
  assign copy_2_o         = out_res.copy[2];
  assign copy_3_o         = out_res.copy[3];
  assign copy_count_o     = out_res.count;
  assign running_total_o  = out_res.total;
  assign final_checksum_o = out_res.final_sum;
  assign checksum_valid_o = out_res.cks_valid;

endmodule
